FILE: sv/gtc_pkg.sv
`timescale 1ns / 1ps
// Package for the touch gesture classifier: widths, register map, reset values,
// flag positions and the structs shared between its modules. No dependencies.
package gtc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;

  // threshold register widths
  localparam int TTIME_BITS = 16;
  localparam int TDIST_BITS = 12;
  localparam int TSQ_BITS   = 2 * TDIST_BITS;

  // APB port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_TAP_TIME_LIM   = 3'd0,
    REG_TAP_MAX_DIST   = 3'd1,
    REG_SWIPE_MIN_DIST = 3'd2,
    REG_SWIPE_TIME_LIM = 3'd3,
    REG_HOLD_TIME_THR  = 3'd4
  } gtc_reg_idx_t;

  localparam logic [TTIME_BITS-1:0] RST_TAP_TIME_LIM   = 16'd300;
  localparam logic [TDIST_BITS-1:0] RST_TAP_MAX_DIST   = 12'd20;
  localparam logic [TDIST_BITS-1:0] RST_SWIPE_MIN_DIST = 12'd50;
  localparam logic [TTIME_BITS-1:0] RST_SWIPE_TIME_LIM = 16'd500;
  localparam logic [TTIME_BITS-1:0] RST_HOLD_TIME_THR  = 16'd800;
  localparam logic [TSQ_BITS-1:0]   RST_TAP_DIST_SQ    = 24'd400;
  localparam logic [TSQ_BITS-1:0]   RST_SWIPE_DIST_SQ  = 24'd2500;

  // sticky flag bit positions
  localparam int FLAG_BITS  = 3;
  localparam int FLAG_TAP   = 0;
  localparam int FLAG_SWIPE = 1;
  localparam int FLAG_HOLD  = 2;

  // thresholds as seen by the datapath (distances pre-squared)
  typedef struct packed {
    logic [TTIME_BITS-1:0] tap_time_lim;
    logic [TSQ_BITS-1:0]   tap_dist_sq;
    logic [TSQ_BITS-1:0]   swipe_dist_sq;
    logic [TTIME_BITS-1:0] swipe_time_lim;
    logic [TTIME_BITS-1:0] hold_time_thr;
  } gtc_cfg_t;

  // per-item control between the tracking and classifying stages
  typedef struct packed {
    logic rise;
    logic fall;
    logic eval;
    logic active;
  } gtc_ctl_t;

endpackage

FILE: sv/gtc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for touch samples and classifier results.
// Depends on gtc_pkg for default widths.
interface gtc_in_if #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = gtc_pkg::TIME_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  touch_down;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [TIME_BITS-1:0]  time_ms;

  modport source (output valid, touch_down, pos_x, pos_y, time_ms, input ready);
  modport sink   (input valid, touch_down, pos_x, pos_y, time_ms, output ready);
endinterface

interface gtc_out_if #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = gtc_pkg::TIME_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  tap;
  logic                  swipe;
  logic                  hold;
  logic                  active;
  logic                  pressed_edge;
  logic                  released_edge;
  logic [TIME_BITS-1:0]  duration_ms;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, tap, swipe, hold, active, pressed_edge, released_edge,
                  duration_ms, end_x, end_y, input ready);
  modport sink   (input valid, tap, swipe, hold, active, pressed_edge, released_edge,
                  duration_ms, end_x, end_y, output ready);
endinterface

FILE: sv/touch_gesture_classifier.sv
`timescale 1ns / 1ps
// Touch gesture classifier: top level, handshake control and assertions.
// Depends on gtc_pkg, gtc_if, gtc_cfg_regs, gtc_track and gtc_classify.
//
// Takes one touch sample (contact, X, Y, ms timestamp) per item and returns one
// result per item: sticky tap/swipe/hold flags of the current or last gesture,
// the active flag, one-sample press and release edges, elapsed time and end
// point. Throughput is one item per clock unless out_ch.ready stalls the output;
// a result passes through two register stages, the front stage and the output
// register, before it is valid. The first stage detects edges, latches the
// gesture start and forms the elapsed time and per-axis distances; the second
// squares and sums the distances and compares against the thresholds; distance
// thresholds are squared once when the APB registers are written. Input ready is
// high whenever the front stage is empty or the pipeline can move, so a sample
// is still taken while a finished result waits on the output. Thresholds are
// written over APB (registers at 0x00 tap time limit, 0x04 tap_max_dist,
// 0x08 swipe_min_dist, 0x0C swipe time limit, 0x10 hold time threshold) and
// should only change while no item is in flight.
module touch_gesture_classifier #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = gtc_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gtc_in_if.sink                            in_ch,
  gtc_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gtc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [gtc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [gtc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  gtc_pkg::gtc_cfg_t             cfg;
  gtc_pkg::gtc_ctl_t             s1_ctl;
  logic [TIME_BITS-1:0]          s1_dur;
  logic [COORD_BITS-1:0]         s1_dx;
  logic [COORD_BITS-1:0]         s1_dy;
  logic [COORD_BITS-1:0]         s1_x;
  logic [COORD_BITS-1:0]         s1_y;
  logic [gtc_pkg::FLAG_BITS-1:0] flags;

  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;
  logic en_out;     // output register free or being drained
  logic s1_fire;    // front stage item moves to the output register
  logic in_ready;
  logic in_fire;

  assign en_out    = ~out_v_r | out_ch.ready;
  assign s1_fire   = s1_v_r & en_out;
  assign in_ready  = ~s1_v_r | en_out;
  assign in_fire   = in_ch.valid & in_ready;
  assign s1_v_nxt  = in_fire | (s1_v_r & ~en_out);
  assign out_v_nxt = s1_fire | (out_v_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  gtc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtc_track #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .touch_down (in_ch.touch_down),
    .pos_x      (in_ch.pos_x),
    .pos_y      (in_ch.pos_y),
    .time_ms    (in_ch.time_ms),
    .ctl_r      (s1_ctl),
    .dur_r      (s1_dur),
    .dx_r       (s1_dx),
    .dy_r       (s1_dy),
    .x_r        (s1_x),
    .y_r        (s1_y)
  );

  gtc_classify #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_fire    (s1_fire),
    .ctl        (s1_ctl),
    .dur        (s1_dur),
    .dx         (s1_dx),
    .dy         (s1_dy),
    .x          (s1_x),
    .y          (s1_y),
    .cfg        (cfg),
    .flags_r    (flags),
    .active_r   (out_ch.active),
    .pressed_r  (out_ch.pressed_edge),
    .released_r (out_ch.released_edge),
    .dur_last_r (out_ch.duration_ms),
    .end_x_r    (out_ch.end_x),
    .end_y_r    (out_ch.end_y)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.tap   = flags[gtc_pkg::FLAG_TAP];
  assign out_ch.swipe = flags[gtc_pkg::FLAG_SWIPE];
  assign out_ch.hold  = flags[gtc_pkg::FLAG_HOLD];

  // a press always leaves the gesture active, with zero elapsed time
  a_press_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.pressed_edge |-> out_ch.active && !out_ch.released_edge)
    else $error("press edge without active gesture");

  a_press_zero_dur: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.pressed_edge |-> out_ch.duration_ms == '0)
    else $error("press edge with nonzero duration");

  // a release always ends the gesture
  a_release_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.released_edge |-> !out_ch.active)
    else $error("release edge with gesture still active");

  // a front-stage item that could not move must still be held next cycle
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !en_out |=> s1_v_r && !in_fire || s1_v_r)
    else $error("front stage item dropped under stall");

endmodule

FILE: sv/gtc_cfg_regs.sv
`timescale 1ns / 1ps
// APB threshold registers; distance thresholds are squared on write.
// Depends on gtc_pkg.
module gtc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gtc_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [gtc_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [gtc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output gtc_pkg::gtc_cfg_t                  cfg
);

  logic [gtc_pkg::TTIME_BITS-1:0] tap_time_lim_r;
  logic [gtc_pkg::TDIST_BITS-1:0] tap_max_dist_r;
  logic [gtc_pkg::TDIST_BITS-1:0] swipe_min_dist_r;
  logic [gtc_pkg::TTIME_BITS-1:0] swipe_time_lim_r;
  logic [gtc_pkg::TTIME_BITS-1:0] hold_time_thr_r;
  logic [gtc_pkg::TSQ_BITS-1:0]   tap_dist_sq_r;
  logic [gtc_pkg::TSQ_BITS-1:0]   swipe_dist_sq_r;

  gtc_pkg::gtc_reg_idx_t          idx;
  logic                           wr;
  logic [gtc_pkg::TDIST_BITS-1:0] wdist;
  logic [gtc_pkg::TSQ_BITS-1:0]   wsq;

  assign idx    = gtc_pkg::gtc_reg_idx_t'(paddr[gtc_pkg::APB_ADDR_BITS-1:2]);
  assign wr     = psel & penable & pwrite;
  assign wdist  = pwdata[gtc_pkg::TDIST_BITS-1:0];
  assign wsq    = gtc_pkg::TSQ_BITS'(wdist) * gtc_pkg::TSQ_BITS'(wdist);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_time_lim_r   <= gtc_pkg::RST_TAP_TIME_LIM;
      tap_max_dist_r   <= gtc_pkg::RST_TAP_MAX_DIST;
      swipe_min_dist_r <= gtc_pkg::RST_SWIPE_MIN_DIST;
      swipe_time_lim_r <= gtc_pkg::RST_SWIPE_TIME_LIM;
      hold_time_thr_r  <= gtc_pkg::RST_HOLD_TIME_THR;
      tap_dist_sq_r    <= gtc_pkg::RST_TAP_DIST_SQ;
      swipe_dist_sq_r  <= gtc_pkg::RST_SWIPE_DIST_SQ;
    end else if (wr) begin
      case (idx)
        gtc_pkg::REG_TAP_TIME_LIM: begin
          tap_time_lim_r <= pwdata[gtc_pkg::TTIME_BITS-1:0];
        end
        gtc_pkg::REG_TAP_MAX_DIST: begin
          tap_max_dist_r <= wdist;
          tap_dist_sq_r  <= wsq;
        end
        gtc_pkg::REG_SWIPE_MIN_DIST: begin
          swipe_min_dist_r <= wdist;
          swipe_dist_sq_r  <= wsq;
        end
        gtc_pkg::REG_SWIPE_TIME_LIM: begin
          swipe_time_lim_r <= pwdata[gtc_pkg::TTIME_BITS-1:0];
        end
        gtc_pkg::REG_HOLD_TIME_THR: begin
          hold_time_thr_r <= pwdata[gtc_pkg::TTIME_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      gtc_pkg::REG_TAP_TIME_LIM:   prdata = gtc_pkg::APB_DATA_BITS'(tap_time_lim_r);
      gtc_pkg::REG_TAP_MAX_DIST:   prdata = gtc_pkg::APB_DATA_BITS'(tap_max_dist_r);
      gtc_pkg::REG_SWIPE_MIN_DIST: prdata = gtc_pkg::APB_DATA_BITS'(swipe_min_dist_r);
      gtc_pkg::REG_SWIPE_TIME_LIM: prdata = gtc_pkg::APB_DATA_BITS'(swipe_time_lim_r);
      gtc_pkg::REG_HOLD_TIME_THR:  prdata = gtc_pkg::APB_DATA_BITS'(hold_time_thr_r);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.tap_time_lim   = tap_time_lim_r;
  assign cfg.tap_dist_sq    = tap_dist_sq_r;
  assign cfg.swipe_dist_sq  = swipe_dist_sq_r;
  assign cfg.swipe_time_lim = swipe_time_lim_r;
  assign cfg.hold_time_thr  = hold_time_thr_r;

endmodule

FILE: sv/gtc_track.sv
`timescale 1ns / 1ps
// Front stage: contact edge detection, gesture start latch, elapsed time and
// per-axis distance from the start point. Depends on gtc_pkg.
module gtc_track #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = gtc_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic                  touch_down,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [TIME_BITS-1:0]  time_ms,
  output gtc_pkg::gtc_ctl_t     ctl_r,
  output logic [TIME_BITS-1:0]  dur_r,
  output logic [COORD_BITS-1:0] dx_r,
  output logic [COORD_BITS-1:0] dy_r,
  output logic [COORD_BITS-1:0] x_r,
  output logic [COORD_BITS-1:0] y_r
);

  logic                  prev_down_r;
  logic                  in_progress_r;
  logic [TIME_BITS-1:0]  start_time_r;
  logic [COORD_BITS-1:0] start_x_r;
  logic [COORD_BITS-1:0] start_y_r;

  gtc_pkg::gtc_ctl_t     ctl_nxt;
  logic [TIME_BITS-1:0]  dur_nxt;
  logic [COORD_BITS-1:0] dx_nxt;
  logic [COORD_BITS-1:0] dy_nxt;

  always_comb begin
    ctl_nxt.rise   = touch_down & ~prev_down_r;
    ctl_nxt.fall   = ~touch_down & prev_down_r;
    ctl_nxt.eval   = ctl_nxt.rise | in_progress_r;
    ctl_nxt.active = ctl_nxt.eval & touch_down;
    // on a rising edge the sample is its own start point
    if (ctl_nxt.rise) begin
      dur_nxt = '0;
      dx_nxt  = '0;
      dy_nxt  = '0;
    end else begin
      dur_nxt = time_ms - start_time_r;   // wraps modulo 2^TIME_BITS
      dx_nxt  = (pos_x >= start_x_r) ? (pos_x - start_x_r) : (start_x_r - pos_x);
      dy_nxt  = (pos_y >= start_y_r) ? (pos_y - start_y_r) : (start_y_r - pos_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_down_r   <= 1'b0;
      in_progress_r <= 1'b0;
      start_time_r  <= '0;
      start_x_r     <= '0;
      start_y_r     <= '0;
    end else if (in_fire) begin
      prev_down_r   <= touch_down;
      in_progress_r <= ctl_nxt.active;
      if (ctl_nxt.rise) begin
        start_time_r <= time_ms;
        start_x_r    <= pos_x;
        start_y_r    <= pos_y;
      end
    end
  end

  // stage payload, qualified by the valid bit in the top level
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ctl_r <= ctl_nxt;
      dur_r <= dur_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      x_r   <= pos_x;
      y_r   <= pos_y;
    end
  end

endmodule

FILE: sv/gtc_classify.sv
`timescale 1ns / 1ps
// Back stage: squared distance, threshold tests, sticky flags and the
// last-gesture record, which doubles as the result register. Depends on gtc_pkg.
module gtc_classify #(
  parameter int COORD_BITS = gtc_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = gtc_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s1_fire,
  input  gtc_pkg::gtc_ctl_t               ctl,
  input  logic [TIME_BITS-1:0]            dur,
  input  logic [COORD_BITS-1:0]           dx,
  input  logic [COORD_BITS-1:0]           dy,
  input  logic [COORD_BITS-1:0]           x,
  input  logic [COORD_BITS-1:0]           y,
  input  gtc_pkg::gtc_cfg_t               cfg,
  output logic [gtc_pkg::FLAG_BITS-1:0]   flags_r,
  output logic                            active_r,
  output logic                            pressed_r,
  output logic                            released_r,
  output logic [TIME_BITS-1:0]            dur_last_r,
  output logic [COORD_BITS-1:0]           end_x_r,
  output logic [COORD_BITS-1:0]           end_y_r
);

  localparam int SQW  = 2 * COORD_BITS;
  localparam int D2W  = SQW + 1;
  localparam int CMPW = (D2W > gtc_pkg::TSQ_BITS) ? D2W : gtc_pkg::TSQ_BITS;

  logic [SQW-1:0]                dx2;
  logic [SQW-1:0]                dy2;
  logic [D2W-1:0]                d2;
  logic                          tap_hit;
  logic                          swipe_hit;
  logic                          hold_hit;
  logic [gtc_pkg::FLAG_BITS-1:0] flags_nxt;

  assign dx2 = SQW'(dx) * SQW'(dx);
  assign dy2 = SQW'(dy) * SQW'(dy);
  assign d2  = D2W'(dx2) + D2W'(dy2);

  assign tap_hit   = (dur <= TIME_BITS'(cfg.tap_time_lim)) &&
                     (CMPW'(d2) <= CMPW'(cfg.tap_dist_sq));
  assign swipe_hit = (CMPW'(d2) >= CMPW'(cfg.swipe_dist_sq)) &&
                     (dur <= TIME_BITS'(cfg.swipe_time_lim));
  assign hold_hit  = (dur >= TIME_BITS'(cfg.hold_time_thr));

  always_comb begin
    flags_nxt = ctl.rise ? '0 : flags_r;
    if (ctl.eval) begin
      flags_nxt[gtc_pkg::FLAG_TAP]   = flags_nxt[gtc_pkg::FLAG_TAP]   | tap_hit;
      flags_nxt[gtc_pkg::FLAG_SWIPE] = flags_nxt[gtc_pkg::FLAG_SWIPE] | swipe_hit;
      flags_nxt[gtc_pkg::FLAG_HOLD]  = flags_nxt[gtc_pkg::FLAG_HOLD]  | hold_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      active_r   <= 1'b0;
      pressed_r  <= 1'b0;
      released_r <= 1'b0;
      dur_last_r <= '0;
      end_x_r    <= '0;
      end_y_r    <= '0;
    end else if (s1_fire) begin
      flags_r    <= flags_nxt;
      active_r   <= ctl.active;
      pressed_r  <= ctl.rise;
      released_r <= ctl.fall;
      if (ctl.eval) begin
        dur_last_r <= dur;
        end_x_r    <= x;
        end_y_r    <= y;
      end
    end
  end

endmodule
